// ----- rtl/mfir_pkg.sv -----
// Shared types and constants for the multichannel FIR filter.
// No dependencies; imported by the top level, mfir_ctrl and mfir_datapath.
`default_nettype none
package mfir_pkg;

  localparam int CHANNELS = 64;
  localparam int MAX_TAPS = 128;   // ring slots per channel, power of two

  localparam int CH_W     = 6;
  localparam int CMD_W    = 2;
  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 16;
  localparam int TIDX_W   = 7;
  localparam int CNT_W    = 8;     // tap_count register
  localparam int VALUE_W  = 39;
  localparam int PROD_W   = SAMPLE_W + TAP_W;

  localparam int POS_W    = $clog2(MAX_TAPS);
  localparam int FILL_W   = $clog2(MAX_TAPS + 1);
  localparam int HIST_DEPTH = CHANNELS * MAX_TAPS;

  localparam logic [CNT_W-1:0] TAP_COUNT_RESET = CNT_W'(128);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_TAP = 2'd0,
    CMD_PUSH     = 2'd1,
    CMD_RESTART  = 2'd2
  } mfir_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } mfir_state_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [FILL_W-1:0] fill;
  } mfir_meta_t;

  localparam int META_W = $bits(mfir_meta_t);

  // controller -> datapath
  typedef struct packed {
    logic tap_wr;     // write tap from the accepted beat
    logic restart;    // clear all fill counts
    logic meta_rd;    // capture push beat, read channel metadata
    logic meta_upd;   // store sample, update ring position and fill
    logic mac_start;  // clear accumulator and tap counter
    logic mac_issue;  // issue one window read
    logic out_load;   // move sum into the output register
  } mfir_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ch_ok;      // channel on the input port is in range
    logic win_full;   // window complete after this push (valid in META)
    logic issue_last; // current issue is the last tap
    logic pipe_busy;  // products still in flight
  } mfir_sts_t;

endpackage
`default_nettype wire

// ----- rtl/multichannel_fir_correlator.sv -----
// Multichannel FIR filter, top level: controller plus datapath.
// Depends on mfir_pkg, mfir_ctrl, mfir_datapath (and mfir_ram below it).
//
//  channel  handshake           payload
//  in       in_valid/in_ready   in_cmd, in_channel, in_sample, in_tap_index, in_tap_value
//  out      out_valid/out_ready out_channel, out_value
//  cfg      cfg_we              cfg_wdata (tap_count)
//
// Tap load, restart and unused codes are taken in IDLE. A push whose window is not
// yet full only stores its sample and updates its metadata; a push with a full window
// also runs the single MAC, which reads one history slot and one tap per cycle.
// Results wait in an output register; a new input beat is taken meanwhile, and a
// finished sum stalls in the controller only while that register is still full.
// Reset is synchronous; no clearing pass, valid bits stand in for reset metadata.
`default_nettype none
module multichannel_fir_correlator (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [mfir_pkg::CNT_W-1:0]           cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [mfir_pkg::CMD_W-1:0]           in_cmd,
  input  wire logic [mfir_pkg::CH_W-1:0]            in_channel,
  input  wire logic signed [mfir_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [mfir_pkg::TIDX_W-1:0]          in_tap_index,
  input  wire logic signed [mfir_pkg::TAP_W-1:0]    in_tap_value,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [mfir_pkg::CH_W-1:0]                 out_channel,
  output logic signed [mfir_pkg::VALUE_W-1:0]       out_value
);
  import mfir_pkg::*;

  mfir_cmd_t dp_cmd;
  mfir_sts_t dp_sts;

  mfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  mfir_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_channel   (in_channel),
    .in_sample    (in_sample),
    .in_tap_index (in_tap_index),
    .in_tap_value (in_tap_value),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .out_channel  (out_channel),
    .out_value    (out_value)
  );

  // sum is handed over only once the MAC pipeline has drained
  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> !dp_sts.pipe_busy)
    else $error("output loaded with products in flight");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // a push that reads metadata occupies the block next cycle
  a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.meta_rd |=> (!in_ready && dp_cmd.meta_upd))
    else $error("push did not advance to metadata update");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.tap_wr, dp_cmd.restart, dp_cmd.meta_rd, dp_cmd.meta_upd,
              dp_cmd.mac_issue, dp_cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule
`default_nettype wire

// ----- rtl/mfir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/mfir_datapath.sv -----
// Datapath: sample history, taps, per-channel ring metadata, shared MAC,
// tap_count register and output payload. Depends on mfir_pkg, mfir_ram.
`default_nettype none
module mfir_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mfir_pkg::CNT_W-1:0]       cfg_wdata,
  input  wire logic [mfir_pkg::CH_W-1:0]        in_channel,
  input  wire logic signed [mfir_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [mfir_pkg::TIDX_W-1:0]      in_tap_index,
  input  wire logic signed [mfir_pkg::TAP_W-1:0] in_tap_value,
  input  wire mfir_pkg::mfir_cmd_t              cmd,
  output mfir_pkg::mfir_sts_t                   sts,
  output logic [mfir_pkg::CH_W-1:0]             out_channel,
  output logic signed [mfir_pkg::VALUE_W-1:0]   out_value
);
  import mfir_pkg::*;

  localparam int HADDR_W = $clog2(HIST_DEPTH);

  logic [CNT_W-1:0]           tap_count_r;
  logic [CH_W-1:0]            ch_r;
  logic [SAMPLE_W-1:0]        sample_r;
  logic [POS_W-1:0]           start_r, start_nxt;
  logic [POS_W-1:0]           dt_r;
  logic                       rd_vld_r, prod_vld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [VALUE_W-1:0]  acc_r;
  logic [CHANNELS-1:0]        pos_vld_r, fill_vld_r;
  logic [CH_W-1:0]            out_channel_r;
  logic signed [VALUE_W-1:0]  out_value_r;

  logic [FILL_W-1:0]  t_use;
  mfir_meta_t         meta_rdata, meta_wdata;
  logic [POS_W-1:0]   pos_cur;
  logic [FILL_W-1:0]  fill_cur, fill_new;
  logic [SAMPLE_W-1:0] hist_rdata;
  logic [TAP_W-1:0]   tap_rdata;
  logic [HADDR_W-1:0] hist_waddr, hist_raddr;
  logic               tap_we;

  // taps in use: zero acts as one, above MAX_TAPS saturates
  always_comb begin
    if (tap_count_r == '0) begin
      t_use = FILL_W'(1);
    end else if ((CNT_W + 1)'(tap_count_r) > (CNT_W + 1)'(MAX_TAPS)) begin
      t_use = FILL_W'(MAX_TAPS);
    end else begin
      t_use = FILL_W'(tap_count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RESET;
    end else if (cfg_we) begin
      tap_count_r <= cfg_wdata;
    end
  end

  // ---- per-channel ring position and fill count ----
  always_comb begin
    pos_cur  = pos_vld_r[ch_r]  ? meta_rdata.pos  : '0;
    fill_cur = fill_vld_r[ch_r] ? meta_rdata.fill : '0;
    fill_new = (fill_cur < FILL_W'(MAX_TAPS)) ? fill_cur + FILL_W'(1) : fill_cur;
    meta_wdata.pos  = pos_cur + POS_W'(1);
    meta_wdata.fill = fill_new;
    // oldest window slot sits t_use slots before the next write slot
    start_nxt = meta_wdata.pos - t_use[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_vld_r  <= '0;
      fill_vld_r <= '0;
    end else if (cmd.restart) begin
      fill_vld_r <= '0;
    end else if (cmd.meta_upd) begin
      pos_vld_r[ch_r]  <= 1'b1;
      fill_vld_r[ch_r] <= 1'b1;
    end
  end

  mfir_ram #(.WIDTH(META_W), .DEPTH(CHANNELS)) u_meta_ram (
    .clk   (clk),
    .we    (cmd.meta_upd),
    .waddr (ch_r),
    .wdata (meta_wdata),
    .raddr (in_channel),
    .rdata (meta_rdata)
  );

  // ---- history and taps ----
  assign hist_waddr = {ch_r, pos_cur};
  assign hist_raddr = {ch_r, start_r + dt_r};

  mfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.meta_upd),
    .waddr (hist_waddr),
    .wdata (sample_r),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  assign tap_we = cmd.tap_wr && ((TIDX_W + 1)'(in_tap_index) < (TIDX_W + 1)'(MAX_TAPS));

  mfir_ram #(.WIDTH(TAP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (in_tap_index[POS_W-1:0]),
    .wdata (in_tap_value),
    .raddr (dt_r),
    .rdata (tap_rdata)
  );

  // ---- capture and MAC pipeline: read -> multiply -> accumulate ----
  always_ff @(posedge clk) begin
    if (cmd.meta_rd) begin
      ch_r     <= in_channel;
      sample_r <= in_sample;
    end
    if (cmd.mac_start) begin
      start_r <= start_nxt;
    end
    if (cmd.mac_start) begin
      dt_r <= '0;
    end else if (cmd.mac_issue) begin
      dt_r <= dt_r + POS_W'(1);
    end
    prod_r <= $signed(hist_rdata) * $signed(tap_rdata);
    if (cmd.mac_start) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + VALUE_W'(prod_r);
    end
    if (cmd.out_load) begin
      out_channel_r <= ch_r;
      out_value_r   <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.mac_issue;
      prod_vld_r <= rd_vld_r;
    end
  end

  always_comb begin
    sts.ch_ok      = (CH_W + 1)'(in_channel) < (CH_W + 1)'(CHANNELS);
    sts.win_full   = fill_new >= t_use;
    sts.issue_last = FILL_W'(dt_r) == t_use - FILL_W'(1);
    sts.pipe_busy  = rd_vld_r || prod_vld_r;
  end

  assign out_channel = out_channel_r;
  assign out_value   = out_value_r;

endmodule
`default_nettype wire

// ----- rtl/mfir_ctrl.sv -----
// Controller: sequences tap loads, restarts and pushes, runs the MAC loop
// and owns the output valid flag. Depends on mfir_pkg.
`default_nettype none
module mfir_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mfir_pkg::CMD_W-1:0]  in_cmd,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  input  wire mfir_pkg::mfir_sts_t         sts,
  output mfir_pkg::mfir_cmd_t              cmd
);
  import mfir_pkg::*;

  mfir_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        beat;
  logic        is_push;
  logic        out_free;

  assign beat     = in_valid && (state_r == ST_IDLE);
  assign is_push  = (in_cmd == CMD_PUSH) && sts.ch_ok;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (beat && is_push) state_nxt = ST_META;
      ST_META:  state_nxt = sts.win_full ? ST_ISSUE : ST_IDLE;
      ST_ISSUE: if (sts.issue_last) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!sts.pipe_busy) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.tap_wr  = beat && (in_cmd == CMD_LOAD_TAP);
        cmd.restart = beat && (in_cmd == CMD_RESTART);
        cmd.meta_rd = beat && is_push;
      end
      ST_META: begin
        cmd.meta_upd  = 1'b1;
        cmd.mac_start = sts.win_full;
      end
      ST_ISSUE: cmd.mac_issue = 1'b1;
      ST_DRAIN: cmd = '0;
      ST_DONE:  cmd.out_load = out_free;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
